/* hw/rtl/rkc_pkg.sv */
`default_nettype none

package rkc_pkg;

   // Geometry and arithmetic constants
   localparam int unsigned DEFAULT_MAX_WIDTH = 1024;
   localparam int unsigned MAX_HEIGHT        = 1024;
   localparam int unsigned KERNEL_SIZE       = 3;
   localparam int unsigned COEF_FRAC_BITS    = 4;
   localparam int unsigned DIM_W             = 11;
   localparam int unsigned CSR_DATA_W        = 30;
   localparam int unsigned CSR_INDEX_W       = 3;
   localparam int unsigned EMIT_W            = 22;
   localparam int unsigned PROD_W            = 17;
   localparam int unsigned COL_SUM_W         = 19;
   localparam int unsigned ACC_W             = 21;
   localparam int unsigned SUM_W             = ACC_W + 1;
   localparam int unsigned FIELD_W           = 10;
   localparam logic [7:0]  PIXEL_MAX         = 8'd255;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_IMAGE_WIDTH   = 3'd0,
      REG_IMAGE_HEIGHT  = 3'd1,
      REG_KERNEL_TOP    = 3'd2,
      REG_KERNEL_MIDDLE = 3'd3,
      REG_KERNEL_BOTTOM = 3'd4,
      REG_BIAS          = 3'd5,
      REG_THRESHOLD     = 3'd6,
      REG_FILTER_ENABLE = 3'd7
   } csr_index_type;

   typedef logic [31:0] pixel_type;
   typedef pixel_type [KERNEL_SIZE-1:0] column_type;
   typedef logic [7:0] coef_type;
   typedef coef_type [KERNEL_SIZE-1:0] coef_column_type;
   typedef logic signed [COL_SUM_W-1:0] col_sum_type;

   typedef struct packed {
      logic                   advance;
      logic                   load;
      logic [KERNEL_SIZE-1:0] row_mask;
      logic                   col_mask;
   } cell_ctrl_type;

   // Clamp a channel sum into a pixel value
   function automatic logic [7:0] normalize(input logic signed [SUM_W-1:0] s,
                                            input logic [FIELD_W-1:0] thr);
      logic signed [SUM_W-1:0] t;
      logic [7:0]              r;
      t = $signed({{(SUM_W-FIELD_W){1'b0}}, thr});
      if (s < 0) begin
         r = 8'd0;
      end else if (s > t) begin
         r = (s >= $signed({{(SUM_W-8){1'b0}}, PIXEL_MAX})) ? PIXEL_MAX : 8'd0;
      end else begin
         r = s[7:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/rkc_tap_cell.sv */
`default_nettype none

module rkc_tap_cell (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire rkc_pkg::cell_ctrl_type   ctrl,
   input  wire rkc_pkg::column_type      column_in,
   input  wire rkc_pkg::coef_column_type coefs,
   output rkc_pkg::column_type           column_ff,
   output rkc_pkg::col_sum_type          col_sum_ff [3]
);

   logic [7:0]                          pix_sel [rkc_pkg::KERNEL_SIZE][3];
   logic signed [rkc_pkg::PROD_W-1:0]   prod_in [rkc_pkg::KERNEL_SIZE][3];
   logic signed [rkc_pkg::PROD_W-1:0]   prod_ff [rkc_pkg::KERNEL_SIZE][3];
   rkc_pkg::col_sum_type                col_sum_in [3];

   // Hold one window column, hand it to the left neighbor on load
   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
      end else if (ctrl.load) begin
         column_ff <= column_in;
      end
   end

   // Multiply the incoming column by its coefficients, padding masked taps
   always_comb begin
      for (int r = 0; r < rkc_pkg::KERNEL_SIZE; r++) begin
         for (int ch = 0; ch < 3; ch++) begin
            pix_sel[r][ch] = (ctrl.row_mask[r] && ctrl.col_mask) ?
                             column_in[r][8*ch +: 8] : 8'd0;
            prod_in[r][ch] =
               $signed({{(rkc_pkg::PROD_W-8){1'b0}}, pix_sel[r][ch]}) *
               $signed({{(rkc_pkg::PROD_W-8){coefs[r][7]}}, coefs[r]});
         end
      end
   end

   // Add the three rows of the column per channel
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         col_sum_in[ch] =
            rkc_pkg::COL_SUM_W'(prod_ff[0][ch]) +
            rkc_pkg::COL_SUM_W'(prod_ff[1][ch]) +
            rkc_pkg::COL_SUM_W'(prod_ff[2][ch]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         prod_ff    <= prod_in;
         col_sum_ff <= col_sum_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/rgb_kernel_convolution.sv */
// rgb_kernel_convolution: 3x3 convolution of an RGBA raster stream.
// Input channel (req_*): one pixel per beat in raster order; req_filler marks
// a flush beat. After the last pixel of a frame send image_width+1 filler
// beats. Result channel (rsp_*): filtered RGB plus the centre alpha;
// rsp_frame_end marks the last pixel of the frame. Both channels move a beat
// when valid is high and stall is low. Configuration (csr_*): write-only
// registers the user must write while the block idles; the block has no guard.
// Throughput: one beat per cycle while no result waits under rsp_stall. The
// result of pixel (R, C) is computed when the beat at (R+1, C+1) is accepted
// and passes the line-memory read, tap-cell products, column sums and normalize.
// The line memory has one read and one write port; back-to-back beats on
// the same column are served by a bypass of the last write.
// Reset clears counters, window cells and pipeline valids and loads the
// register defaults; the line memory is not cleared, since edge padding
// masks every entry not yet written in a frame.
// A stalled result freezes the whole pipeline, and req_stall rises for as
// long as rsp_valid waits under rsp_stall.
`default_nettype none

module rgb_kernel_convolution #(
   parameter int unsigned MAX_WIDTH = rkc_pkg::DEFAULT_MAX_WIDTH
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [7:0]                        req_in_red,
   input  wire logic [7:0]                        req_in_green,
   input  wire logic [7:0]                        req_in_blue,
   input  wire logic [7:0]                        req_in_alpha,
   input  wire logic                              req_filler,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [7:0]                             rsp_out_red,
   output logic [7:0]                             rsp_out_green,
   output logic [7:0]                             rsp_out_blue,
   output logic [7:0]                             rsp_out_alpha,
   output logic                                   rsp_frame_end,
   input  wire logic                              csr_write_enable,
   input  wire logic [rkc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [rkc_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   localparam int unsigned COL_W   = $clog2(MAX_WIDTH);
   localparam int unsigned W_CLAMP = (MAX_WIDTH > 2047) ? 2047 : MAX_WIDTH;
   localparam int unsigned CMP_W   = ((COL_W > rkc_pkg::DIM_W) ? COL_W : rkc_pkg::DIM_W) + 1;
   localparam int unsigned DW      = rkc_pkg::DIM_W;
   localparam int unsigned EW      = rkc_pkg::EMIT_W;
   localparam int unsigned FW      = rkc_pkg::FIELD_W;
   localparam logic [DW-1:0] ROW_LIMIT = '1;

   // Configuration registers
   logic [DW-1:0] width_ff, height_ff;
   logic [23:0]   krow_ff [3];
   logic [29:0]   bias_ff, thr_ff;
   logic          enable_ff;

   // Frame counters
   logic [COL_W-1:0] col_ff, col_in;
   logic [DW-1:0]    row_ff, row_in;
   logic [EW-1:0]    emitted_ff, emitted_in, total_ff;

   // Stage 0 decode
   logic             en, accept;
   logic [DW-1:0]    w, h;
   logic [COL_W-1:0] cin;
   logic             cin_ge1, due, over, emit, last, wrap;
   logic [CMP_W-1:0] cc, col_next;
   logic [DW-1:0]    cr;
   logic [EW-1:0]    emit_next;
   logic [2:0]       row_mask, col_mask;

   // Stage 1: memory read and window shift
   logic [63:0]             mem [MAX_WIDTH];
   logic [63:0]             rd_ff, fwd_data_ff, old_word;
   logic                    fwd_ff;
   logic                    s1_valid_ff, s1_emit_ff, s1_end_ff;
   rkc_pkg::pixel_type      s1_pix_ff;
   logic [COL_W-1:0]        s1_cin_ff;
   logic [2:0]              s1_row_mask_ff, s1_col_mask_ff;
   rkc_pkg::column_type     colv;

   // Tap cells
   rkc_pkg::column_type      cell_column [3];
   rkc_pkg::col_sum_type     cell_sum [3][3];
   rkc_pkg::coef_column_type cell_coefs [3];
   rkc_pkg::cell_ctrl_type   cell_ctrl [3];

   // Stages 2 and 3
   logic               s2_valid_ff, s2_end_ff, s3_valid_ff, s3_end_ff;
   rkc_pkg::pixel_type s2_centre_ff, s3_centre_ff;
   logic signed [rkc_pkg::ACC_W-1:0] acc [3], acc_sh [3];
   logic signed [rkc_pkg::SUM_W-1:0] chan_sum [3];
   logic [7:0]                       chan_res [3];
   logic [9:0]                       bias_f [3];

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= DW'(640);
         height_ff  <= DW'(480);
         krow_ff[0] <= 24'd0;
         krow_ff[1] <= 24'd4096;
         krow_ff[2] <= 24'd0;
         bias_ff    <= 30'd0;
         thr_ff     <= 30'd267648255;
         enable_ff  <= 1'b1;
      end else if (csr_write_enable) begin
         unique case (rkc_pkg::csr_index_type'(csr_index))
            rkc_pkg::REG_IMAGE_WIDTH:   width_ff   <= csr_write_data[DW-1:0];
            rkc_pkg::REG_IMAGE_HEIGHT:  height_ff  <= csr_write_data[DW-1:0];
            rkc_pkg::REG_KERNEL_TOP:    krow_ff[0] <= csr_write_data[23:0];
            rkc_pkg::REG_KERNEL_MIDDLE: krow_ff[1] <= csr_write_data[23:0];
            rkc_pkg::REG_KERNEL_BOTTOM: krow_ff[2] <= csr_write_data[23:0];
            rkc_pkg::REG_BIAS:          bias_ff    <= csr_write_data[29:0];
            rkc_pkg::REG_THRESHOLD:     thr_ff     <= csr_write_data[29:0];
            rkc_pkg::REG_FILTER_ENABLE: enable_ff  <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // Clamp the geometry
   always_comb begin
      w = (width_ff == '0) ? DW'(1) :
          (width_ff > DW'(W_CLAMP)) ? DW'(W_CLAMP) : width_ff;
      h = (height_ff == '0) ? DW'(1) :
          (height_ff > DW'(rkc_pkg::MAX_HEIGHT)) ? DW'(rkc_pkg::MAX_HEIGHT) : height_ff;
   end

   // Pixel count of a frame, registered after the multiply
   always_ff @(posedge clock) begin
      total_ff <= EW'(w) * EW'(h);
   end

   // Advance the pipeline unless a result waits under stall
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;
   assign accept    = req_valid && en;

   // Position, due test and edge masks of the beat
   always_comb begin
      cin      = (CMP_W'(col_ff) >= CMP_W'(w)) ? '0 : col_ff;
      cin_ge1  = (cin != '0);
      due      = (row_ff > DW'(1)) || ((row_ff == DW'(1)) && cin_ge1);
      cc       = cin_ge1 ? CMP_W'(cin) - CMP_W'(1) : CMP_W'(w) - CMP_W'(1);
      cr       = cin_ge1 ? row_ff - DW'(1) : row_ff - DW'(2);
      col_mask[0] = (cc != '0);
      col_mask[1] = 1'b1;
      col_mask[2] = (cc + CMP_W'(1)) < CMP_W'(w);
      row_mask[0] = (cr != '0);
      row_mask[1] = CMP_W'(cr) < CMP_W'(h);
      row_mask[2] = (CMP_W'(cr) + CMP_W'(1)) < CMP_W'(h);
      col_next = CMP_W'(cin) + CMP_W'(1);
      wrap     = col_next >= CMP_W'(w);
      over      = due && (emitted_ff >= total_ff);
      emit      = due && !over;
      emit_next = emitted_ff + EW'(1);
      last      = emit && (emit_next >= total_ff);
      col_in     = wrap ? '0 : col_next[COL_W-1:0];
      row_in     = (wrap && (row_ff != ROW_LIMIT)) ? row_ff + DW'(1) : row_ff;
      emitted_in = emit ? emit_next : emitted_ff;
      if (over || last) begin
         col_in     = '0;
         row_in     = '0;
         emitted_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         emitted_ff <= '0;
      end else if (accept) begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         emitted_ff <= emitted_in;
      end
   end

   // Line memory: read on accept, write back from stage 1
   always_comb begin
      old_word = fwd_ff ? fwd_data_ff : rd_ff;
      colv[0]  = old_word[31:0];
      colv[1]  = old_word[63:32];
      colv[2]  = s1_pix_ff;
   end

   always_ff @(posedge clock) begin
      if (en && s1_valid_ff) begin
         mem[s1_cin_ff] <= {s1_pix_ff, colv[1]};
      end
      if (accept) begin
         rd_ff       <= mem[cin];
         fwd_data_ff <= {s1_pix_ff, colv[1]};
      end
   end

   // Stage 1 control and payload
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= accept;
         if (accept) begin
            fwd_ff <= s1_valid_ff && (s1_cin_ff == cin);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff      <= req_filler ? '0 :
                           {req_in_alpha, req_in_blue, req_in_green, req_in_red};
         s1_cin_ff      <= cin;
         s1_emit_ff     <= emit;
         s1_end_ff      <= last;
         s1_row_mask_ff <= row_mask;
         s1_col_mask_ff <= col_mask;
      end
   end

   // Coefficients and control of each tap cell
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         for (int i = 0; i < 3; i++) begin
            cell_coefs[j][i] = krow_ff[i][8*j +: 8];
         end
         cell_ctrl[j].advance  = en;
         cell_ctrl[j].load     = en && s1_valid_ff;
         cell_ctrl[j].row_mask = s1_row_mask_ff;
         cell_ctrl[j].col_mask = s1_col_mask_ff[j];
      end
   end

   // Chain of tap cells, new column enters at the right
   for (genvar j = 0; j < 3; j++) begin : g_cell
      rkc_tap_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl[j]),
         .column_in  ((j == 2) ? colv : cell_column[(j == 2) ? 2 : j + 1]),
         .coefs      (cell_coefs[j]),
         .column_ff  (cell_column[j]),
         .col_sum_ff (cell_sum[j])
      );
   end

   // Carry the centre pixel and flags alongside the taps
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff && s1_emit_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_centre_ff <= cell_column[2][1];
         s2_end_ff    <= s1_end_ff;
         s3_centre_ff <= s2_centre_ff;
         s3_end_ff    <= s2_end_ff;
      end
   end

   // Sum the columns, floor, add bias and normalize; pass the centre if disabled
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         acc[ch] = rkc_pkg::ACC_W'(cell_sum[0][ch]) +
                   rkc_pkg::ACC_W'(cell_sum[1][ch]) +
                   rkc_pkg::ACC_W'(cell_sum[2][ch]);
         acc_sh[ch]   = acc[ch] >>> rkc_pkg::COEF_FRAC_BITS;
         bias_f[ch]   = bias_ff[FW*ch +: FW];
         chan_sum[ch] = $signed({acc_sh[ch][rkc_pkg::ACC_W-1], acc_sh[ch]}) +
                        $signed({{(rkc_pkg::SUM_W-FW){bias_f[ch][FW-1]}}, bias_f[ch]});
         chan_res[ch] = enable_ff ?
                        rkc_pkg::normalize(chan_sum[ch], thr_ff[FW*ch +: FW]) :
                        s3_centre_ff[8*ch +: 8];
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (en) begin
         rsp_valid <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en && s3_valid_ff) begin
         rsp_out_red   <= chan_res[0];
         rsp_out_green <= chan_res[1];
         rsp_out_blue  <= chan_res[2];
         rsp_out_alpha <= s3_centre_ff[31:24];
         rsp_frame_end <= s3_end_ff;
      end
   end

   // Stall on the input only while a result is held back
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a held result");

   // Same-column beats back to back must take the bypass
   assert property (@(posedge clock) disable iff (reset)
      (accept && s1_valid_ff && (s1_cin_ff == cin)) |=> fwd_ff)
      else $error("line memory bypass missed");

   // A bubble in stage 1 gives no tap result
   assert property (@(posedge clock) disable iff (reset)
      (en && !s1_valid_ff) |=> !s2_valid_ff)
      else $error("tap stage valid without an item");

   // A frozen pipeline keeps its stage valids
   assert property (@(posedge clock) disable iff (reset)
      !en |=> ($stable(s2_valid_ff) && $stable(s3_valid_ff)))
      else $error("pipeline moved while frozen");

endmodule

`default_nettype wire
